[rtl/core/section_cycle_profiler_top_defines.svh]
// ---------------------------------------------------------------------------
// section cycle profiler assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef SECTION_CYCLE_PROFILER_TOP_DEFINES_SVH
`define SECTION_CYCLE_PROFILER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("profiler check failed");

// next-cycle implication, disabled during reset
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("profiler check failed");

`endif

[rtl/core/scp_pkg.sv]
// ---------------------------------------------------------------------------
// scp_pkg
// shared types and constants of the section cycle profiler
// ---------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int unsigned SECTIONS_DEF = 16;
  localparam int unsigned DW           = 32;
  localparam int unsigned SEC_W        = 4;
  localparam int unsigned ACT_W        = 2;

  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  localparam logic [DW-1:0] MIN_EMPTY = 32'hFFFF_FFFF;

  // one section table entry
  typedef struct packed {
    logic [DW-1:0] start_stamp;
    logic [DW-1:0] last_time;
    logic [DW-1:0] min_time;
    logic [DW-1:0] max_time;
  } scp_entry_t;

  localparam int unsigned ENTRY_W = $bits(scp_entry_t);

  localparam scp_entry_t ENTRY_RESET = '{
    start_stamp: '0,
    last_time:   '0,
    min_time:    MIN_EMPTY,
    max_time:    '0
  };

  // request control handed to the update logic
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             in_range;
  } scp_ctl_t;

  // update result handed back to the sequencer
  typedef struct packed {
    logic [DW-1:0] counter;
    scp_entry_t    entry;
    logic          wr;
    logic          clr;
  } scp_upd_t;

endpackage

`default_nettype wire

[rtl/core/scp_if.sv]
// ---------------------------------------------------------------------------
// scp interfaces
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface scp_req_if;
  logic                      valid;
  logic                      ready;
  logic [scp_pkg::ACT_W-1:0] action;
  logic [scp_pkg::SEC_W-1:0] section;

  modport source (output valid, output action, output section, input ready);
  modport sink   (input valid, input action, input section, output ready);
endinterface

interface scp_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [scp_pkg::DW-1:0] counter_now;
  logic [scp_pkg::DW-1:0] last_elapsed;
  logic [scp_pkg::DW-1:0] min_elapsed;
  logic [scp_pkg::DW-1:0] max_elapsed;

  modport source (output valid, output counter_now, output last_elapsed,
                  output min_elapsed, output max_elapsed, input ready);
  modport sink   (input valid, input counter_now, input last_elapsed,
                  input min_elapsed, input max_elapsed, output ready);
endinterface

`default_nettype wire

[rtl/core/scp_ram.sv]
// ---------------------------------------------------------------------------
// scp_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module scp_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/scp_update.sv]
// ---------------------------------------------------------------------------
// scp_update
// read-modify step: counter advance and section entry update
// ---------------------------------------------------------------------------
`default_nettype none

module scp_update (
  input  scp_pkg::scp_ctl_t   ctl,
  input  logic                counter_enable,
  input  logic [scp_pkg::DW-1:0] counter,
  input  scp_pkg::scp_entry_t entry,
  output scp_pkg::scp_upd_t   upd
);

  logic [scp_pkg::DW-1:0] elapsed;

  // wraps modulo 2^32 by construction
  assign elapsed = counter - entry.start_stamp;

  always_comb begin
    upd         = '0;
    upd.counter = counter;
    upd.entry   = entry;
    case (ctl.action)
      scp_pkg::ACT_TICK: begin
        if (counter_enable) begin
          upd.counter = counter + 32'd1;
        end
      end
      scp_pkg::ACT_START: begin
        if (ctl.in_range) begin
          upd.entry.start_stamp = counter;
          upd.wr                = 1'b1;
        end
      end
      scp_pkg::ACT_STOP: begin
        if (ctl.in_range) begin
          upd.entry.last_time = elapsed;
          if (entry.max_time < elapsed) begin
            upd.entry.max_time = elapsed;
          end
          if (entry.min_time > elapsed) begin
            upd.entry.min_time = elapsed;
          end
          upd.wr = 1'b1;
        end
      end
      scp_pkg::ACT_CLEAR: begin
        if (ctl.in_range) begin
          upd.entry = scp_pkg::ENTRY_RESET;
          upd.clr   = 1'b1;
        end
      end
      default: begin
        upd.entry = entry;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/section_cycle_profiler_top.sv]
// ---------------------------------------------------------------------------
// section_cycle_profiler_top
// cycle counter with per-section start, last, min and max elapsed times
// ---------------------------------------------------------------------------
// A request is accepted in the idle state, which issues the table read; the
// execute state then updates the entry, writes it back and loads the result
// register, and waits while the result register holds a result not yet
// taken. No new request is accepted until the execute state is done. The
// result register decouples the response side, so the next request is
// accepted while an earlier result still waits to be taken. Each section
// entry (start stamp, last, min, max) sits in one ram word; a valid bit per
// section stands for the reset state, so there is no clearing pass after
// reset and the block takes requests as soon as reset is released. A clear
// request only drops the valid bit. Requests whose section index is not
// below SECTIONS change no entry and report zero times; ticks still count.
// counter_enable resets to 1 and is written through cfg_write/cfg_data.
// ---------------------------------------------------------------------------
`default_nettype none

module section_cycle_profiler_top #(
  parameter int unsigned SECTIONS = scp_pkg::SECTIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_data,
  scp_req_if.sink      req,
  scp_rsp_if.source    rsp
);

  localparam int unsigned AW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // configuration and counter
  logic                   counter_enable;
  logic [scp_pkg::DW-1:0] counter;

  // per-section valid bits, cleared means reset values
  logic [SECTIONS-1:0] vld;

  // captured request
  logic [scp_pkg::ACT_W-1:0] action_q;
  logic [AW-1:0]             addr_q;
  logic                      in_range_q;

  // result register
  logic                   rsp_valid;
  logic [scp_pkg::DW-1:0] rsp_counter;
  logic [scp_pkg::DW-1:0] rsp_last;
  logic [scp_pkg::DW-1:0] rsp_min;
  logic [scp_pkg::DW-1:0] rsp_max;

  logic                         req_take;
  logic                         go;
  logic                         req_in_range;
  logic [scp_pkg::ENTRY_W-1:0]  rd_data;
  scp_pkg::scp_entry_t          cur_entry;
  scp_pkg::scp_ctl_t            ctl;
  scp_pkg::scp_upd_t            upd;

  // accept only while no request is being executed
  assign req.ready    = (state == S_IDLE);
  assign req_take     = req.valid && req.ready;
  assign req_in_range = (32'(req.section) < 32'(SECTIONS));

  // execute once the result register is free or being emptied
  assign go = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  scp_ram #(
    .WIDTH (scp_pkg::ENTRY_W),
    .DEPTH (SECTIONS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (go && upd.wr),
    .wr_addr (addr_q),
    .wr_data (upd.entry),
    .rd_en   (req_take),
    .rd_addr (AW'(req.section)),
    .rd_data (rd_data)
  );

  // entry not written since reset or clear reads as reset values
  assign cur_entry = vld[addr_q] ? scp_pkg::scp_entry_t'(rd_data)
                                 : scp_pkg::ENTRY_RESET;

  assign ctl.action   = action_q;
  assign ctl.in_range = in_range_q;

  scp_update u_update (
    .ctl            (ctl),
    .counter_enable (counter_enable),
    .counter        (counter),
    .entry          (cur_entry),
    .upd            (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      counter_enable <= 1'b1;
      counter        <= '0;
      vld            <= '0;
    end else begin
      if (cfg_write) begin
        counter_enable <= cfg_data;
      end

      // a new result replaces the one taken in the same cycle
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_take) begin
            action_q   <= req.action;
            addr_q     <= AW'(req.section);
            in_range_q <= req_in_range;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            counter <= upd.counter;
            if (upd.wr) begin
              vld[addr_q] <= 1'b1;
            end
            if (upd.clr) begin
              vld[addr_q] <= 1'b0;
            end
            // result fields are zero for an out-of-range section
            rsp_counter <= upd.counter;
            rsp_last    <= in_range_q ? upd.entry.last_time : '0;
            rsp_min     <= in_range_q ? upd.entry.min_time  : '0;
            rsp_max     <= in_range_q ? upd.entry.max_time  : '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.counter_now  = rsp_counter;
  assign rsp.last_elapsed = rsp_last;
  assign rsp.min_elapsed  = rsp_min;
  assign rsp.max_elapsed  = rsp_max;

endmodule

`default_nettype wire

[rtl/core/scp_checker.sv]
// ---------------------------------------------------------------------------
// scp_checker
// port-level checks of the section cycle profiler, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "section_cycle_profiler_top_defines.svh"

module scp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [scp_pkg::DW-1:0] rsp_counter_now,
  input logic [scp_pkg::DW-1:0] rsp_last_elapsed,
  input logic [scp_pkg::DW-1:0] rsp_min_elapsed,
  input logic [scp_pkg::DW-1:0] rsp_max_elapsed
);

  logic [scp_pkg::DW-1:0] prev_counter;

  // counter value of the last result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_counter <= '0;
    end else if (rsp_valid && rsp_ready) begin
      prev_counter <= rsp_counter_now;
    end
  end

  // one request in flight at a time
  `SCP_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // a held result keeps its payload
  `SCP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_counter_now) && $stable(rsp_last_elapsed) && $stable(rsp_min_elapsed) && $stable(rsp_max_elapsed))

  // each request advances the counter by at most one
  `SCP_ASSERT_NOW(a_counter_step, clk, rst, rsp_valid, rsp_counter_now == prev_counter || rsp_counter_now == prev_counter + 32'd1)

  // either no stop seen yet, or last lies between min and max
  `SCP_ASSERT_NOW(a_stats_order, clk, rst, rsp_valid, (rsp_min_elapsed <= rsp_last_elapsed && rsp_last_elapsed <= rsp_max_elapsed) || (rsp_min_elapsed == scp_pkg::MIN_EMPTY && rsp_max_elapsed == '0 && rsp_last_elapsed == '0))

endmodule

bind section_cycle_profiler_top scp_checker u_scp_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_counter_now  (rsp.counter_now),
  .rsp_last_elapsed (rsp.last_elapsed),
  .rsp_min_elapsed  (rsp.min_elapsed),
  .rsp_max_elapsed  (rsp.max_elapsed)
);

`default_nettype wire
